/* sv/line_follow_pid_controller_assert.svh */
`ifndef LINE_FOLLOW_PID_CONTROLLER_ASSERT_SVH
`define LINE_FOLLOW_PID_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define LFPID_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfpid assertion failed");

// next-cycle implication
`define LFPID_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfpid assertion failed");

`endif

/* sv/lfpid_pkg.sv */
package lfpid_pkg;

    localparam int SensorCount = 8;
    localparam int IdxW        = $clog2(SensorCount);
    localparam int SensorW     = 17;
    localparam int SumW        = SensorW + IdxW;
    localparam int SqW         = 2 * SensorW + IdxW;
    localparam int MW          = SqW + IdxW;
    localparam int XW          = MW + 20;
    localparam int RootW       = XW / 2;
    localparam int RemW        = RootW + 2;
    localparam int WeightW     = 4;
    localparam int WtW         = 22;
    localparam int MagW        = WtW - 1;
    localparam int NumW        = MagW + IdxW + 22;
    localparam int DenW        = RootW + 1;
    localparam int PosW        = 16;
    localparam int QW          = 16;
    localparam int GainW       = 20;
    localparam int BaseW       = 16;
    localparam int LimW        = 19;
    localparam int IntW        = 20;
    localparam int SpeedW      = 20;
    localparam int OpW         = 21;
    localparam int ProdW       = 2 * OpW;
    localparam int TotW        = 44;
    localparam int CorrW       = TotW - 20;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 20;
    localparam int RootCntW    = $clog2(RootW);
    localparam int DivCntW     = $clog2(QW);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_BASE_SPEED     = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQUARE,
        ST_SPREAD,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_PID_P,
        ST_PID_I,
        ST_PID_D,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        RD_IDLE,
        RD_ROOT,
        RD_CHECK,
        RD_DIV,
        RD_DONE
    } t_rd_state;

    typedef struct packed {
        logic [SensorW-1:0] sensor_0;
        logic [SensorW-1:0] sensor_1;
        logic [SensorW-1:0] sensor_2;
        logic [SensorW-1:0] sensor_3;
        logic [SensorW-1:0] sensor_4;
        logic [SensorW-1:0] sensor_5;
        logic [SensorW-1:0] sensor_6;
        logic [SensorW-1:0] sensor_7;
    } t_in;

    typedef struct packed {
        logic signed [SpeedW-1:0] left_speed;
        logic signed [SpeedW-1:0] right_speed;
        logic signed [PosW-1:0]   line_position;
    } t_out;

    function automatic logic signed [WeightW-1:0] weight_of(input logic [IdxW-1:0] k);
        int half;
        int w;
        half = SensorCount / 2;
        if (int'(k) < half) w = half - int'(k);
        else if (int'(k) >= SensorCount - half) w = -(int'(k) - (SensorCount - half) + 1);
        else w = 0;
        return WeightW'(w);
    endfunction

endpackage

/* sv/lfpid_root_div.sv */
module lfpid_root_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lfpid_pkg::MW-1:0]    i_m,
    input  logic [lfpid_pkg::MagW-1:0]  i_mag,
    output logic                        o_done,
    output logic [lfpid_pkg::QW-1:0]    o_q
);
    import lfpid_pkg::*;

    t_rd_state           r_state, n_state;
    logic [XW-1:0]       r_x;
    logic [RemW-1:0]     r_rem;
    logic [RootW-1:0]    r_root;
    logic [RootCntW-1:0] r_rcnt;
    logic [DivCntW-1:0]  r_dcnt;
    logic [MagW-1:0]     r_mag;
    logic [NumW-1:0]     r_num;
    logic [NumW-1:0]     r_dsh;
    logic [QW-1:0]       r_q;

    logic [RemW+1:0]     w_rem_sh;
    logic [RemW+1:0]     w_trial;
    logic                w_root_ge;
    logic [NumW-1:0]     w_num;
    logic [NumW:0]       w_lim;
    logic                w_div_ge;

    assign w_rem_sh  = {r_rem, r_x[XW-1 -: 2]};
    assign w_trial   = (RemW+2)'({r_root, 2'b01});
    assign w_root_ge = w_rem_sh >= w_trial;
    assign w_num     = NumW'({r_mag, {(IdxW+21){1'b0}}}) + NumW'(r_root);
    assign w_lim     = {r_root, 1'b0, {QW{1'b0}}};
    assign w_div_ge  = r_num >= r_dsh;

    always_comb begin
        n_state = r_state;
        case (r_state)
            RD_IDLE:  if (i_start) n_state = (i_m == '0) ? RD_DONE : RD_ROOT;
            RD_ROOT:  if (r_rcnt == '0) n_state = RD_CHECK;
            RD_CHECK: n_state = ({1'b0, w_num} >= w_lim) ? RD_DONE : RD_DIV;
            RD_DIV:   if (r_dcnt == '0) n_state = RD_DONE;
            RD_DONE:  n_state = RD_IDLE;
            default:  n_state = RD_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == RD_DONE);
        o_q    = r_q[QW-1] ? {1'b0, {(QW-1){1'b1}}} : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= RD_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            RD_IDLE: begin
                r_x    <= {i_m, {(XW-MW){1'b0}}};
                r_rem  <= '0;
                r_root <= '0;
                r_rcnt <= RootCntW'(RootW - 1);
                r_mag  <= i_mag;
                r_q    <= '0;
            end
            RD_ROOT: begin
                r_x    <= {r_x[XW-3:0], 2'b00};
                r_rem  <= w_root_ge ? RemW'(w_rem_sh - w_trial) : RemW'(w_rem_sh);
                r_root <= {r_root[RootW-2:0], w_root_ge};
                r_rcnt <= r_rcnt - 1'b1;
            end
            RD_CHECK: begin
                r_num  <= w_num;
                r_dsh  <= NumW'({r_root, 1'b0, {(QW-1){1'b0}}});
                r_dcnt <= DivCntW'(QW - 1);
                r_q    <= ({1'b0, w_num} >= w_lim) ? '1 : '0;
            end
            RD_DIV: begin
                r_num  <= w_div_ge ? r_num - r_dsh : r_num;
                r_dsh  <= r_dsh >> 1;
                r_q    <= {r_q[QW-2:0], w_div_ge};
                r_dcnt <= r_dcnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

/* sv/line_follow_pid_controller.sv */
// Line follower PID controller for an eight-sensor reflectance bar. One frame of readings
// is taken when o_ready is high; the line position (weighted sum over the standard
// deviation) and the left and right wheel speeds come out as one result transaction.
// A frame accumulates the sums one sensor a cycle, then runs a bit-serial square root and
// a restoring divide, then goes through the P, I and D steps of the shared PID multiplier;
// a frame with all readings equal skips the root and divide. Gains and limits must be
// written on the configuration port only while the block is idle; it does not enforce this.
`include "line_follow_pid_controller_assert.svh"

module line_follow_pid_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  lfpid_pkg::t_in                    i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output lfpid_pkg::t_out                   o_data,
    input  logic                              i_cfg_we,
    input  logic [lfpid_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [lfpid_pkg::CfgDataW-1:0]    i_cfg_data
);
    import lfpid_pkg::*;

    t_state                 r_state, n_state;
    t_in                    r_frame;
    logic [IdxW-1:0]        r_idx;
    logic [SumW-1:0]        r_s_sum;
    logic [SqW-1:0]         r_sq_sum;
    logic signed [WtW-1:0]  r_w;
    logic [MW-1:0]          r_ssq;
    logic [MW-1:0]          r_m;
    logic signed [PosW-1:0] r_pos;
    logic signed [IntW-1:0] r_integral;
    logic signed [PosW-1:0] r_prev;
    logic signed [PosW+1:0] r_diff;
    logic signed [TotW-1:0] r_tot;
    logic                   r_out_valid;
    t_out                   r_out;

    logic [GainW-1:0]       r_gain_p, r_gain_i, r_gain_d;
    logic [BaseW-1:0]       r_base;
    logic [LimW-1:0]        r_lim;

    logic                   w_root_start;
    logic                   w_root_done;
    logic [QW-1:0]          w_q;
    logic [SensorW-1:0]     w_v;
    logic [MagW-1:0]        w_mag;
    logic [MW-1:0]          w_eight_q;
    logic signed [PosW:0]   w_err;
    logic signed [IntW:0]   w_acc_raw;
    logic signed [IntW:0]   w_lim_s;
    logic signed [IntW-1:0] w_acc;
    logic signed [OpW-1:0]  w_op_a, w_op_b;
    logic signed [ProdW-1:0] w_prod;
    logic signed [TotW-1:0] w_round;
    logic signed [CorrW-1:0] w_corr;
    logic signed [CorrW:0]  w_left, w_right, w_base_s;
    logic                   w_load_out;

    function automatic logic [SensorW-1:0] sensor_at(input t_in d, input logic [IdxW-1:0] k);
        logic [SensorW-1:0] v;
        case (k)
            3'd0:    v = d.sensor_0;
            3'd1:    v = d.sensor_1;
            3'd2:    v = d.sensor_2;
            3'd3:    v = d.sensor_3;
            3'd4:    v = d.sensor_4;
            3'd5:    v = d.sensor_5;
            3'd6:    v = d.sensor_6;
            default: v = d.sensor_7;
        endcase
        return v;
    endfunction

    function automatic logic signed [SpeedW-1:0] sat_speed(input logic signed [CorrW:0] x);
        logic signed [SpeedW-1:0] y;
        if (x > (CorrW+1)'(signed'({1'b0, {(SpeedW-1){1'b1}}}))) y = {1'b0, {(SpeedW-1){1'b1}}};
        else if (x < -(CorrW+1)'(signed'({2'b01, {(SpeedW-1){1'b0}}})))
            y = {1'b1, {(SpeedW-1){1'b0}}};
        else y = SpeedW'(x);
        return y;
    endfunction

    assign w_v       = sensor_at(r_frame, r_idx);
    assign w_mag     = r_w[WtW-1] ? MagW'(-r_w) : MagW'(r_w);
    assign w_eight_q = {r_sq_sum, {IdxW{1'b0}}};
    assign w_err     = -(PosW+1)'(r_pos);
    assign w_acc_raw = (IntW+1)'(r_integral) + (IntW+1)'(w_err);
    assign w_lim_s   = signed'((IntW+1)'(r_lim));
    assign w_acc     = (w_acc_raw > w_lim_s) ? IntW'(w_lim_s) :
                       (w_acc_raw < -w_lim_s) ? IntW'(-w_lim_s) : IntW'(w_acc_raw);

    always_comb begin
        case (r_state)
            ST_PID_I: begin
                w_op_a = signed'(OpW'(r_gain_i));
                w_op_b = OpW'(r_integral);
            end
            ST_PID_D: begin
                w_op_a = signed'(OpW'(r_gain_d));
                w_op_b = OpW'(r_diff);
            end
            default: begin
                w_op_a = signed'(OpW'(r_gain_p));
                w_op_b = OpW'(w_err);
            end
        endcase
    end

    assign w_prod   = w_op_a * w_op_b;
    assign w_round  = r_tot + TotW'(signed'({1'b0, 1'b1, 19'd0}));
    assign w_corr   = w_round[TotW-1:20];
    assign w_base_s = signed'((CorrW+1)'(r_base));
    assign w_left   = w_base_s - (CorrW+1)'(w_corr);
    assign w_right  = w_base_s + (CorrW+1)'(w_corr);

    lfpid_root_div u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_m     (r_m),
        .i_mag   (w_mag),
        .o_done  (w_root_done),
        .o_q     (w_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (i_valid) n_state = ST_ACC;
            ST_ACC:        if (r_idx == IdxW'(SensorCount - 1)) n_state = ST_SQUARE;
            ST_SQUARE:     n_state = ST_SPREAD;
            ST_SPREAD:     n_state = ST_ROOT_START;
            ST_ROOT_START: n_state = ST_ROOT_WAIT;
            ST_ROOT_WAIT:  if (w_root_done) n_state = ST_PID_P;
            ST_PID_P:      n_state = ST_PID_I;
            ST_PID_I:      n_state = ST_PID_D;
            ST_PID_D:      n_state = ST_FINISH;
            ST_FINISH:     if (!r_out_valid || i_ready) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = (r_state == ST_IDLE);
        w_root_start = (r_state == ST_ROOT_START);
        w_load_out   = (r_state == ST_FINISH) && (!r_out_valid || i_ready);
        o_valid      = r_out_valid;
        o_data       = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_integral  <= '0;
            r_prev      <= '0;
            r_gain_p    <= GainW'(73400);
            r_gain_i    <= GainW'(5243);
            r_gain_d    <= GainW'(105);
            r_base      <= BaseW'(3215);
            r_lim       <= LimW'(204800);
        end else begin
            r_state <= n_state;
            if (w_load_out) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            if (r_state == ST_PID_P) begin
                r_integral <= w_acc;
                r_prev     <= PosW'(w_err);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAIN_P:         r_gain_p <= i_cfg_data[GainW-1:0];
                    CFG_GAIN_I:         r_gain_i <= i_cfg_data[GainW-1:0];
                    CFG_GAIN_D:         r_gain_d <= i_cfg_data[GainW-1:0];
                    CFG_BASE_SPEED:     r_base   <= i_cfg_data[BaseW-1:0];
                    CFG_INTEGRAL_LIMIT: r_lim    <= i_cfg_data[LimW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_frame  <= i_data;
                r_idx    <= '0;
                r_s_sum  <= '0;
                r_sq_sum <= '0;
                r_w      <= '0;
            end
            ST_ACC: begin
                r_s_sum  <= r_s_sum + SumW'(w_v);
                r_sq_sum <= r_sq_sum + SqW'(w_v * w_v);
                r_w      <= r_w + WtW'(weight_of(r_idx) * signed'({1'b0, w_v}));
                r_idx    <= r_idx + 1'b1;
            end
            ST_SQUARE: r_ssq <= MW'(r_s_sum * r_s_sum);
            ST_SPREAD: r_m   <= (w_eight_q > r_ssq) ? w_eight_q - r_ssq : '0;
            ST_ROOT_WAIT: begin
                if (w_root_done) r_pos <= r_w[WtW-1] ? -signed'(w_q) : signed'(w_q);
            end
            ST_PID_P: begin
                r_diff <= (PosW+2)'(w_err) - (PosW+2)'(r_prev);
                r_tot  <= TotW'(w_prod);
            end
            ST_PID_I: r_tot <= r_tot + TotW'(w_prod);
            ST_PID_D: r_tot <= r_tot + TotW'(w_prod);
            ST_FINISH: begin
                if (w_load_out) begin
                    r_out.left_speed    <= sat_speed(w_left);
                    r_out.right_speed   <= sat_speed(w_right);
                    r_out.line_position <= r_pos;
                end
            end
            default: begin
            end
        endcase
    end

    `LFPID_ASSERT_NXT(a_accept_starts_acc, i_valid && o_ready, r_state == ST_ACC)
    `LFPID_ASSERT_IMP(a_root_done_in_wait, w_root_done, r_state == ST_ROOT_WAIT)
    `LFPID_ASSERT_IMP(a_pos_not_min, r_out_valid, o_data.line_position != 16'sh8000)

endmodule
